@@ hw/rtl/ptom_pkg.sv @@
// Package for the price-time order matcher: request and result structs,
// action and status codes, sizing constants. No dependencies.
`default_nettype none
package ptom_pkg;
	localparam int BookSlotsDef = 32;
	localparam int MaxFills = 32;

	typedef enum logic [1:0] {
		ACT_NEW    = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_MODIFY = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	localparam logic KIND_TRADE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic        side;
		logic        is_market;
		logic [31:0] order_id;
		logic [31:0] new_id;
		logic [31:0] limit_price;
		logic [31:0] size;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] buyer_id;
		logic [31:0] seller_id;
		logic [31:0] fill_price;
		logic [31:0] fill_size;
		logic [1:0]  status;
		logic        top_changed;
		logic [31:0] best_bid;
		logic [31:0] best_bid_volume;
		logic [31:0] best_ask;
		logic [31:0] best_ask_volume;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LVL0, S_FIND, S_FILL, S_PLACE, S_IDSCAN, S_APPLY,
		S_LVL1, S_EMIT
	} eng_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/ptom_fifo.sv @@
// Small two-entry queue used between the front, the engine and the ports.
// Depends on nothing; width is a parameter.
`default_nettype none
module ptom_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ptom_engine.sv @@
// Book engine: slot table, one-slot-per-cycle scans for best order, id
// lookup, free slot and level volume. Depends on ptom_pkg.
`default_nettype none
module ptom_engine #(
	parameter int BOOK_SLOTS = ptom_pkg::BookSlotsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire ptom_pkg::req_t req,
	output logic               req_take,
	output logic               res_push,
	output ptom_pkg::res_t     res,
	input  wire logic          res_full
);
	localparam int IW = $clog2(BOOK_SLOTS);

	logic        valid_q [BOOK_SLOTS];
	logic        sside_q [BOOK_SLOTS];
	logic [31:0] sid_q   [BOOK_SLOTS];
	logic [31:0] sprice_q[BOOK_SLOTS];
	logic [31:0] ssize_q [BOOK_SLOTS];
	logic [31:0] sstamp_q[BOOK_SLOTS];
	logic [31:0] arrival_q;

	ptom_pkg::eng_state_t state_q, state_d;
	ptom_pkg::req_t r_q;
	logic [IW-1:0] idx_q;
	logic          pass_q;       // scan pass: 0 find best, 1 sum volume
	logic          lside_q;      // side being leveled
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [31:0]   lvl_price_q;
	logic [32:0]   vol_q;
	logic [31:0]   bb0_q, ba0_q, bb_q, ba_q, bv_q, av_q;
	logic [31:0]   rem_q;
	logic [5:0]    nfill_q;
	logic [1:0]    status_q;
	logic          chg_q;
	logic          have_free_q;
	logic [IW-1:0] free_q;

	// scan element
	logic          cur_v, cur_sd;
	logic [31:0]   cur_p, cur_age, best_age;
	logic          better, last_idx;
	logic          side_mt, id_mt;
	logic          opp;

	assign opp      = !r_q.side;
	assign cur_v    = valid_q[idx_q];
	assign cur_sd   = sside_q[idx_q];
	assign cur_p    = sprice_q[idx_q];
	assign cur_age  = arrival_q - sstamp_q[idx_q];
	assign best_age = arrival_q - sstamp_q[pick_q];
	assign last_idx = idx_q == IW'(BOOK_SLOTS - 1);
	assign side_mt  = cur_v && (cur_sd == lside_q);
	assign id_mt    = cur_v && (sid_q[idx_q] == r_q.order_id);

	// best compare for side lside_q
	always_comb begin
		if (cur_p == sprice_q[pick_q]) better = cur_age > best_age;
		else if (!lside_q) better = cur_p > sprice_q[pick_q];
		else better = cur_p < sprice_q[pick_q];
	end

	// fill arithmetic
	logic [31:0] q_fill, rest_p;
	logic        cross_ok;
	assign rest_p   = sprice_q[pick_q];
	assign q_fill   = (rem_q < ssize_q[pick_q]) ? rem_q : ssize_q[pick_q];
	assign cross_ok = r_q.is_market ||
		(!r_q.side ? (r_q.limit_price >= rest_p) : (r_q.limit_price <= rest_p));

	// free slot, including the slot under the scan on the last cycle
	logic          free_ok;
	logic [IW-1:0] free_at;
	assign free_ok = have_free_q || !cur_v;
	assign free_at = have_free_q ? free_q : idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptom_pkg::S_IDLE:  if (req_valid) state_d = ptom_pkg::S_LVL0;
			ptom_pkg::S_LVL0:
				if (last_idx && pass_q && lside_q) begin
					case (r_q.action)
						ptom_pkg::ACT_NEW:
							state_d = (r_q.size != '0) ? ptom_pkg::S_FIND
								: ptom_pkg::S_LVL1;
						ptom_pkg::ACT_CANCEL, ptom_pkg::ACT_MODIFY:
							state_d = ptom_pkg::S_IDSCAN;
						default: state_d = ptom_pkg::S_LVL1;
					endcase
				end
			ptom_pkg::S_FIND:
				if (last_idx) state_d = ptom_pkg::S_FILL;
			ptom_pkg::S_FILL:
				if (!found_q || !cross_ok) state_d = ptom_pkg::S_PLACE;
				else if (!res_full) begin
					if (rem_q == q_fill || nfill_q == 6'(ptom_pkg::MaxFills - 1))
						state_d = ptom_pkg::S_PLACE;
					else state_d = ptom_pkg::S_FIND;
				end
			ptom_pkg::S_PLACE:  if (last_idx) state_d = ptom_pkg::S_LVL1;
			ptom_pkg::S_IDSCAN: if (last_idx) state_d = ptom_pkg::S_APPLY;
			ptom_pkg::S_APPLY:  state_d = ptom_pkg::S_LVL1;
			ptom_pkg::S_LVL1:
				if (last_idx && pass_q && lside_q) state_d = ptom_pkg::S_EMIT;
			ptom_pkg::S_EMIT:   if (!res_full) state_d = ptom_pkg::S_IDLE;
			default: state_d = ptom_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_take = state_q == ptom_pkg::S_IDLE && req_valid;
		res_push = 1'b0;
		res      = '0;
		if (state_q == ptom_pkg::S_FILL && found_q && cross_ok && !res_full) begin
			res_push       = 1'b1;
			res.kind       = ptom_pkg::KIND_TRADE;
			res.buyer_id   = !r_q.side ? r_q.order_id : sid_q[pick_q];
			res.seller_id  = !r_q.side ? sid_q[pick_q] : r_q.order_id;
			res.fill_price = rest_p;
			res.fill_size  = q_fill;
		end
		if (state_q == ptom_pkg::S_EMIT && !res_full) begin
			res_push            = 1'b1;
			res.kind            = ptom_pkg::KIND_DONE;
			res.status          = status_q;
			res.top_changed     = chg_q || (r_q.action != ptom_pkg::ACT_CANCEL
				&& status_q != ptom_pkg::ST_UNKNOWN && (bb0_q != bb_q || ba0_q != ba_q));
			res.best_bid        = bb_q;
			res.best_bid_volume = bv_q;
			res.best_ask        = ba_q;
			res.best_ask_volume = av_q;
			res.last            = 1'b1;
		end
	end

	// level volume, saturating; the final sum includes the last slot
	logic [32:0] vol_next;
	logic        vol_hit;
	logic [31:0] vol_fin;
	assign vol_next = (vol_q + {1'b0, ssize_q[idx_q]} > 33'hFFFFFFFF)
		? 33'hFFFFFFFF : vol_q + {1'b0, ssize_q[idx_q]};
	assign vol_hit  = side_mt && found_q && cur_p == lvl_price_q;
	assign vol_fin  = vol_hit ? vol_next[31:0] : vol_q[31:0];

	// control and data registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptom_pkg::S_IDLE;
			arrival_q <= '0;
			for (int i = 0; i < BOOK_SLOTS; i++) valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ptom_pkg::S_FILL:
					if (found_q && cross_ok && !res_full) begin
						ssize_q[pick_q] <= ssize_q[pick_q] - q_fill;
						if (ssize_q[pick_q] == q_fill) valid_q[pick_q] <= 1'b0;
					end
				ptom_pkg::S_PLACE:
					if (last_idx && rem_q != '0 && !r_q.is_market && free_ok) begin
						valid_q[free_at]  <= 1'b1;
						sside_q[free_at]  <= r_q.side;
						sid_q[free_at]    <= r_q.order_id;
						sprice_q[free_at] <= r_q.limit_price;
						ssize_q[free_at]  <= rem_q;
						sstamp_q[free_at] <= arrival_q;
						arrival_q         <= arrival_q + 32'd1;
					end
				ptom_pkg::S_APPLY:
					if (found_q) begin
						if (r_q.action == ptom_pkg::ACT_CANCEL) valid_q[pick_q] <= 1'b0;
						else begin
							if (!(r_q.limit_price == sprice_q[pick_q]
								&& r_q.size < ssize_q[pick_q])) begin
								sprice_q[pick_q] <= r_q.limit_price;
								sstamp_q[pick_q] <= arrival_q;
								arrival_q        <= arrival_q + 32'd1;
							end
							sid_q[pick_q]   <= r_q.new_id;
							ssize_q[pick_q] <= r_q.size;
							if (r_q.size == '0) valid_q[pick_q] <= 1'b0;
						end
					end
				default: ;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ptom_pkg::S_IDLE: begin
				r_q <= req; idx_q <= '0; pass_q <= 1'b0; lside_q <= 1'b0;
				found_q <= 1'b0; vol_q <= '0; status_q <= ptom_pkg::ST_OK;
				chg_q <= 1'b0; nfill_q <= '0; rem_q <= req.size;
			end
			ptom_pkg::S_LVL0, ptom_pkg::S_LVL1: begin
				idx_q <= last_idx ? '0 : idx_q + IW'(1);
				if (!pass_q) begin
					if (side_mt && (!found_q || better)) begin
						pick_q <= idx_q; found_q <= 1'b1;
						lvl_price_q <= cur_p;
					end
					if (last_idx) pass_q <= 1'b1;
				end else if (last_idx) begin
					if (!lside_q) begin
						bb_q <= found_q ? lvl_price_q : '0;
						bv_q <= found_q ? vol_fin : '0;
						if (state_q == ptom_pkg::S_LVL0)
							bb0_q <= found_q ? lvl_price_q : '0;
					end else begin
						ba_q <= found_q ? lvl_price_q : '0;
						av_q <= found_q ? vol_fin : '0;
						if (state_q == ptom_pkg::S_LVL0)
							ba0_q <= found_q ? lvl_price_q : '0;
					end
					pass_q  <= 1'b0;
					lside_q <= (lside_q && state_q == ptom_pkg::S_LVL0) ? opp : !lside_q;
					found_q <= 1'b0;
					vol_q   <= '0;
				end else if (vol_hit) vol_q <= vol_next;
			end
			ptom_pkg::S_FIND: begin
				idx_q <= last_idx ? '0 : idx_q + IW'(1);
				if (side_mt && (!found_q || better)) begin
					pick_q <= idx_q; found_q <= 1'b1;
				end
			end
			ptom_pkg::S_FILL: begin
				// hold the pick while the result queue is full
				if (!found_q || !cross_ok || !res_full) begin
					found_q     <= 1'b0;
					idx_q       <= '0;
					have_free_q <= 1'b0;
				end
				if (found_q && cross_ok && !res_full) begin
					rem_q   <= rem_q - q_fill;
					nfill_q <= nfill_q + 6'd1;
				end
			end
			ptom_pkg::S_PLACE: begin
				idx_q <= last_idx ? '0 : idx_q + IW'(1);
				if (!cur_v && !have_free_q) begin
					have_free_q <= 1'b1; free_q <= idx_q;
				end
				if (last_idx) begin
					lside_q <= 1'b0; pass_q <= 1'b0; found_q <= 1'b0; vol_q <= '0;
					if (rem_q != '0 && !r_q.is_market && !free_ok)
						status_q <= ptom_pkg::ST_FULL;
				end
			end
			ptom_pkg::S_IDSCAN: begin
				idx_q <= last_idx ? '0 : idx_q + IW'(1);
				if (id_mt && (!found_q || cur_age < best_age)) begin
					pick_q <= idx_q; found_q <= 1'b1;
				end
			end
			ptom_pkg::S_APPLY: begin
				if (!found_q) status_q <= ptom_pkg::ST_UNKNOWN;
				else if (r_q.action == ptom_pkg::ACT_CANCEL) chg_q <= 1'b1;
				lside_q <= 1'b0; pass_q <= 1'b0; found_q <= 1'b0; vol_q <= '0;
				idx_q <= '0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/price_time_order_matcher.sv @@
// Top level of the price-time order matcher: request queue, book engine,
// result queue. Depends on ptom_pkg, ptom_fifo, ptom_engine.
//
//   channel | handshake        | payload
//   request | push / full      | req (ptom_pkg::req_t)
//   result  | pop / empty      | res (ptom_pkg::res_t), last marks end
//
// A request starts when the engine takes it; a level scan (best pass and
// volume pass on each side) runs before the action and again after it,
// and a completion result ends it. A new order adds a find scan and a fill
// per fill, a find scan that ends matching (not when filled or at the fill
// cap) and the free-slot scan; cancel and modify add the id scan and an
// apply step. One slot is visited per cycle. Reset empties the book and
// both queues at once. A full result queue stalls the engine in place.
`default_nettype none
module price_time_order_matcher #(
	parameter int BOOK_SLOTS = ptom_pkg::BookSlotsDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire ptom_pkg::req_t req,
	input  wire logic           pop,
	output logic                empty,
	output ptom_pkg::res_t      res
);
	ptom_pkg::req_t q_req;
	ptom_pkg::res_t e_res;
	logic q_empty, take, r_push, r_full;

	ptom_fifo #(.W($bits(ptom_pkg::req_t))) u_inq (
		.clk, .arst_n, .push, .din(req), .full,
		.pop(take), .dout(q_req), .empty(q_empty)
	);

	ptom_engine #(.BOOK_SLOTS(BOOK_SLOTS)) u_eng (
		.clk, .arst_n, .req_valid(!q_empty), .req(q_req), .req_take(take),
		.res_push(r_push), .res(e_res), .res_full(r_full)
	);

	ptom_fifo #(.W($bits(ptom_pkg::res_t))) u_outq (
		.clk, .arst_n, .push(r_push), .din(e_res), .full(r_full),
		.pop, .dout(res), .empty
	);
endmodule
`default_nettype wire
